@@ sv/nand_boot_copy_bad_block_skip_defines.svh @@
// Assertion macros for the NAND boot copy engine checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef NAND_BOOT_COPY_BAD_BLOCK_SKIP_DEFINES_SVH
`define NAND_BOOT_COPY_BAD_BLOCK_SKIP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/nbc_pkg.sv @@
// Shared types and constants of the NAND boot copy engine.
// No dependencies; imported by the front, queue, back and checker.
`timescale 1ns / 1ps

package nbc_pkg;

  // result action codes
  localparam logic [2:0] ACT_SELECT   = 3'd0;
  localparam logic [2:0] ACT_UNSELECT = 3'd1;
  localparam logic [2:0] ACT_COMMAND  = 3'd2;
  localparam logic [2:0] ACT_ADDRESS  = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;
  localparam logic [2:0] ACT_MEMWR    = 3'd5;
  localparam logic [2:0] ACT_DONE     = 3'd6;

  // flash command bytes
  localparam logic [7:0] CMD_READ_A = 8'h00;
  localparam logic [7:0] CMD_READ_B = 8'h30;
  localparam logic [7:0] CMD_RESET  = 8'hff;

  localparam int unsigned QUEUE_DEPTH = 4;

  // tail of a job, emitted after the optional memory write and unselect
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_START,
    TAIL_READB,
    TAIL_ISSUE,
    TAIL_DONE
  } tail_e;

  typedef logic [4:0][7:0] addr5_t;

  typedef struct packed {
    logic        memwr_en;
    logic        unsel_en;
    tail_e       tail;
    logic [7:0]  wr_data;
    logic [31:0] wr_addr;
    logic [11:0] rd_count;
    logic        done_status;
    addr5_t      addr_bytes;
  } job_t;

endpackage

@@ sv/nbc_front.sv @@
// Front end of the NAND boot copy engine: accepts items, keeps the copy state
// and turns each item into at most one job for the queue. Depends on nbc_pkg.
`timescale 1ns / 1ps

module nbc_front #(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned PAGE_SHIFT  = 12,
  parameter int unsigned BLOCK_SHIFT = 18,
  parameter int unsigned ADDR_BITS   = 29
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    data_byte_i,
  input  logic [31:0]   dest_base_i,
  input  logic [24:0]   image_bytes_i,
  input  logic          full_i,
  output logic          push_o,
  output nbc_pkg::job_t job_o
);
  import nbc_pkg::*;

  localparam int unsigned FA_W = ADDR_BITS + 1;
  localparam int unsigned BLK_W = ADDR_BITS - BLOCK_SHIFT;
  localparam int unsigned BI_W = $clog2(PAGE_BYTES);

  localparam logic [FA_W-1:0] PAGE_STEP = FA_W'(64'd1 << PAGE_SHIFT);
  localparam logic [FA_W-1:0] BLOCK_STEP = FA_W'(64'd1 << BLOCK_SHIFT);
  localparam logic [FA_W-1:0] PIB_MASK =
    FA_W'(((64'd1 << BLOCK_SHIFT) - 64'd1) & ~((64'd1 << PAGE_SHIFT) - 64'd1));
  localparam logic [FA_W-1:0] SPARE_COL = FA_W'(PAGE_BYTES);
  localparam logic [25:0] PAGE_LEN = 26'(PAGE_BYTES);
  localparam logic [11:0] PAGE_COUNT = 12'(PAGE_BYTES);
  localparam logic [BI_W-1:0] LAST_INDEX = BI_W'(PAGE_BYTES - 1);
  localparam logic [7:0] COL_HI_MASK = 8'(((64'd1 << PAGE_SHIFT) - 64'd1) >> 8);
  localparam logic [7:0] TOP_MASK = 8'(((64'd1 << ADDR_BITS) - 64'd1) >> (PAGE_SHIFT + 16));

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;

  localparam logic [7:0] GOOD_BLOCK = 8'hff;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_RESET_WAIT = 3'd1;
  localparam logic [2:0] PH_SPARE_WAIT = 3'd2;
  localparam logic [2:0] PH_SPARE_DATA = 3'd3;
  localparam logic [2:0] PH_PAGE_WAIT  = 3'd4;
  localparam logic [2:0] PH_PAGE_DATA  = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [FA_W-1:0]  flash_addr_q, flash_addr_d;
  logic [BLK_W-1:0] checked_q, checked_d;
  logic             checked_vld_q, checked_vld_d;
  logic [25:0]      bytes_left_q, bytes_left_d;
  logic [31:0]      write_ptr_q, write_ptr_d;
  logic [BI_W-1:0]  byte_index_q, byte_index_d;

  logic             accept;
  logic             do_proceed;
  logic [FA_W-1:0]  p_addr;
  logic [25:0]      p_bytes;
  logic [BLK_W-1:0] p_blk;
  job_t             job;
  logic             push;

  function automatic addr5_t addr_bytes_of(input logic [FA_W-1:0] a);
    logic [63:0] ax;
    addr5_t      r;
    ax = 64'(a);
    r[0] = ax[7:0];
    r[1] = ax[15:8] & COL_HI_MASK;
    r[2] = ax[PAGE_SHIFT +: 8];
    r[3] = ax[PAGE_SHIFT + 8 +: 8];
    r[4] = ax[PAGE_SHIFT + 16 +: 8] & TOP_MASK;
    return r;
  endfunction

  assign in_stall_o = full_i;
  assign accept = in_valid_i && !full_i;

  always_comb begin
    phase_d       = phase_q;
    flash_addr_d  = flash_addr_q;
    checked_d     = checked_q;
    checked_vld_d = checked_vld_q;
    bytes_left_d  = bytes_left_q;
    write_ptr_d   = write_ptr_q;
    byte_index_d  = byte_index_q;
    job           = '0;
    push          = 1'b0;
    do_proceed    = 1'b0;
    p_addr        = flash_addr_q;
    p_bytes       = bytes_left_q;

    if (accept) begin
      unique case (mode_i)
        MODE_START: begin
          if (phase_q == PH_IDLE) begin
            flash_addr_d  = '0;
            checked_d     = '0;
            checked_vld_d = 1'b0;
            byte_index_d  = '0;
            bytes_left_d  = 26'(image_bytes_i);
            write_ptr_d   = dest_base_i;
            job.tail      = TAIL_START;
            push          = 1'b1;
            phase_d       = PH_RESET_WAIT;
          end
        end
        MODE_READY: begin
          priority case (phase_q)
            PH_RESET_WAIT: begin
              job.unsel_en = 1'b1;
              do_proceed   = 1'b1;
            end
            PH_SPARE_WAIT: begin
              job.tail     = TAIL_READB;
              job.rd_count = 12'd1;
              push         = 1'b1;
              phase_d      = PH_SPARE_DATA;
            end
            PH_PAGE_WAIT: begin
              job.tail     = TAIL_READB;
              job.rd_count = PAGE_COUNT;
              push         = 1'b1;
              byte_index_d = '0;
              phase_d      = PH_PAGE_DATA;
            end
            default: ;
          endcase
        end
        MODE_DATA: begin
          priority case (phase_q)
            PH_SPARE_DATA: begin
              job.unsel_en = 1'b1;
              do_proceed   = 1'b1;
              // bad block: jump to page 0 of the next block
              if (data_byte_i != GOOD_BLOCK) begin
                p_addr = (flash_addr_q & ~PIB_MASK) + BLOCK_STEP;
              end
            end
            PH_PAGE_DATA: begin
              job.memwr_en = 1'b1;
              job.wr_data  = data_byte_i;
              job.wr_addr  = write_ptr_q;
              push         = 1'b1;
              write_ptr_d  = write_ptr_q + 32'd1;
              if (byte_index_q >= LAST_INDEX) begin
                byte_index_d = '0;
                job.unsel_en = 1'b1;
                do_proceed   = 1'b1;
                p_bytes      = (bytes_left_q > PAGE_LEN) ? bytes_left_q - PAGE_LEN : '0;
                p_addr       = flash_addr_q + PAGE_STEP;
              end else begin
                byte_index_d = byte_index_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    p_blk = p_addr[ADDR_BITS-1:BLOCK_SHIFT];

    // pick the next read, or finish
    if (do_proceed) begin
      push         = 1'b1;
      flash_addr_d = p_addr;
      bytes_left_d = p_bytes;
      if (p_bytes == '0) begin
        job.tail        = TAIL_DONE;
        job.done_status = 1'b0;
        phase_d         = PH_IDLE;
      end else if (p_addr[ADDR_BITS]) begin
        job.tail        = TAIL_DONE;
        job.done_status = 1'b1;
        phase_d         = PH_IDLE;
      end else if (!checked_vld_q || p_blk != checked_q) begin
        checked_d      = p_blk;
        checked_vld_d  = 1'b1;
        job.tail       = TAIL_ISSUE;
        job.addr_bytes = addr_bytes_of(p_addr + SPARE_COL);
        phase_d        = PH_SPARE_WAIT;
      end else begin
        job.tail       = TAIL_ISSUE;
        job.addr_bytes = addr_bytes_of(p_addr);
        byte_index_d   = '0;
        phase_d        = PH_PAGE_WAIT;
      end
    end
  end

  assign push_o = push;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      flash_addr_q  <= '0;
      checked_q     <= '0;
      checked_vld_q <= 1'b0;
      bytes_left_q  <= '0;
      write_ptr_q   <= '0;
      byte_index_q  <= '0;
    end else begin
      phase_q       <= phase_d;
      flash_addr_q  <= flash_addr_d;
      checked_q     <= checked_d;
      checked_vld_q <= checked_vld_d;
      bytes_left_q  <= bytes_left_d;
      write_ptr_q   <= write_ptr_d;
      byte_index_q  <= byte_index_d;
    end
  end

endmodule

@@ sv/nbc_fifo.sv @@
// Short job queue between the front and back of the boot copy engine.
// Depends on nbc_pkg for the job type and depth.
`timescale 1ns / 1ps

module nbc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nbc_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output nbc_pkg::job_t head_job_o
);
  import nbc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == FULL_CNT);
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ sv/nbc_back.sv @@
// Back end of the boot copy engine: expands the queue head job into result
// transactions, one a cycle unless stalled, via an output register. Uses nbc_pkg.
`timescale 1ns / 1ps

module nbc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  nbc_pkg::job_t head_job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    action_o,
  output logic [7:0]    value_o,
  output logic [11:0]   byte_count_o,
  output logic [31:0]   mem_addr_o,
  output logic          status_o,
  output logic          last_o
);
  import nbc_pkg::*;

  // slot 0 memory write, slot 1 unselect, slots 2 and up the tail
  logic [3:0]  step_q, step_d;
  logic        started_q, started_d;
  logic [3:0]  slot, first_slot, last_slot, next_slot, tail_len;
  logic [2:0]  t;
  logic [2:0]  abyte;
  logic        is_last, emit;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  action_q, action_d;
  logic [7:0]  value_q, value_d;
  logic [11:0] count_q, count_d;
  logic [31:0] maddr_q, maddr_d;
  logic        status_q, status_d;
  logic        last_q;

  always_comb begin
    unique case (head_job_i.tail)
      TAIL_START: tail_len = 4'd2;
      TAIL_READB: tail_len = 4'd1;
      TAIL_ISSUE: tail_len = 4'd8;
      TAIL_DONE:  tail_len = 4'd1;
      default:    tail_len = 4'd0;
    endcase
  end

  assign first_slot = head_job_i.memwr_en ? 4'd0 : (head_job_i.unsel_en ? 4'd1 : 4'd2);
  assign last_slot  = (tail_len != 4'd0) ? 4'd1 + tail_len
                                          : (head_job_i.unsel_en ? 4'd1 : 4'd0);
  assign slot       = started_q ? step_q : first_slot;
  assign next_slot  = (slot == 4'd0) ? (head_job_i.unsel_en ? 4'd1 : 4'd2) : slot + 4'd1;
  assign is_last    = (slot == last_slot);
  assign t          = 3'(slot - 4'd2);
  assign abyte      = t - 3'd2;

  assign emit  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && is_last;

  always_comb begin
    action_d = ACT_DONE;
    value_d  = '0;
    count_d  = '0;
    maddr_d  = '0;
    status_d = 1'b0;
    if (slot == 4'd0) begin
      action_d = ACT_MEMWR;
      value_d  = head_job_i.wr_data;
      maddr_d  = head_job_i.wr_addr;
    end else if (slot == 4'd1) begin
      action_d = ACT_UNSELECT;
    end else begin
      unique case (head_job_i.tail)
        TAIL_START: begin
          if (t == 3'd0) begin
            action_d = ACT_SELECT;
          end else begin
            action_d = ACT_COMMAND;
            value_d  = CMD_RESET;
          end
        end
        TAIL_READB: begin
          action_d = ACT_READ;
          count_d  = head_job_i.rd_count;
        end
        TAIL_ISSUE: begin
          priority if (t == 3'd0) begin
            action_d = ACT_SELECT;
          end else if (t == 3'd1) begin
            action_d = ACT_COMMAND;
            value_d  = CMD_READ_A;
          end else if (t == 3'd7) begin
            action_d = ACT_COMMAND;
            value_d  = CMD_READ_B;
          end else begin
            action_d = ACT_ADDRESS;
            value_d  = head_job_i.addr_bytes[abyte];
          end
        end
        TAIL_DONE: begin
          action_d = ACT_DONE;
          status_d = head_job_i.done_status;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    step_d    = step_q;
    started_d = started_q;
    if (emit) begin
      if (is_last) begin
        started_d = 1'b0;
      end else begin
        step_d    = next_slot;
        started_d = 1'b1;
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      started_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      action_q <= action_d;
      value_q  <= value_d;
      count_q  <= count_d;
      maddr_q  <= maddr_d;
      status_q <= status_d;
      last_q   <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign value_o      = value_q;
  assign byte_count_o = count_q;
  assign mem_addr_o   = maddr_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

@@ sv/nand_boot_copy_bad_block_skip.sv @@
// Top level of the NAND boot copy engine with bad-block skip: APB registers,
// front end, job queue and back end. Depends on nbc_pkg, nbc_front, nbc_fifo, nbc_back.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid_i, in_stall_o, mode_i, data_byte_i | in
//   result   | out_valid_o, out_stall_i, action_o .. last_o | out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata | APB
//
// An input transaction is taken every cycle while the four-entry job queue has room.
// Results leave one a cycle from the output register while not stalled; an item yields
// up to 10 of them (none when it is ignored), 9 or 10 when it issues a flash read.
// An item reaches the result port at the earliest via the job queue and output register.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps

module nand_boot_copy_bad_block_skip #(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned PAGE_SHIFT  = 12,
  parameter int unsigned BLOCK_SHIFT = 18,
  parameter int unsigned ADDR_BITS   = 29
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  value_o,
  output logic [11:0] byte_count_o,
  output logic [31:0] mem_addr_o,
  output logic        status_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nbc_pkg::*;

  localparam logic REG_DEST_BASE   = 1'b0;
  localparam logic REG_IMAGE_BYTES = 1'b1;

  logic [31:0] dest_base_q;
  logic [24:0] image_bytes_q;
  logic        cfg_wr;

  logic        push, full, pop, head_valid;
  job_t        push_job, head_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IMAGE_BYTES) ? 32'(image_bytes_q) : dest_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_base_q   <= '0;
      image_bytes_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEST_BASE) begin
        dest_base_q <= pwdata;
      end else begin
        image_bytes_q <= pwdata[24:0];
      end
    end
  end

  nbc_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .BLOCK_SHIFT(BLOCK_SHIFT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .dest_base_i  (dest_base_q),
    .image_bytes_i(image_bytes_q),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  nbc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_job_o  (head_job)
  );

  nbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .action_o    (action_o),
    .value_o     (value_o),
    .byte_count_o(byte_count_o),
    .mem_addr_o  (mem_addr_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

@@ sv/nbc_checker.sv @@
// Port-level checker for the NAND boot copy engine, bound to the top level.
// Depends on nbc_pkg and nand_boot_copy_bad_block_skip_defines.svh.
`timescale 1ns / 1ps
`include "nand_boot_copy_bad_block_skip_defines.svh"

module nbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [7:0]  value_o,
  input logic [11:0] byte_count_o,
  input logic [31:0] mem_addr_o,
  input logic        status_o,
  input logic        last_o
);
  import nbc_pkg::*;

  // a stalled result holds
  `NBC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(action_o) && $stable(value_o) && $stable(byte_count_o) && $stable(mem_addr_o) && $stable(last_o), "stalled result changed")

  // done and read requests always close a transaction's results
  `NBC_ASSERT_NOW(a_tail_last, out_valid_o && (action_o == ACT_DONE || action_o == ACT_READ), last_o, "done or read not marked last")

  // select is always followed by a command from the same item
  `NBC_ASSERT_NOW(a_select_not_last, out_valid_o && action_o == ACT_SELECT, !last_o, "select marked last")

  // memory writes carry no count or status
  `NBC_ASSERT_NOW(a_memwr_clean, out_valid_o && action_o == ACT_MEMWR, byte_count_o == 12'd0 && status_o == 1'b0, "memory write with stray fields")

endmodule

bind nand_boot_copy_bad_block_skip nbc_checker u_nbc_checker (.*);

@@ test/testbench.sv @@
// Self-checking bench for nand_boot_copy_bad_block_skip: a flash responder feeds
// start, ready and data transactions; a scoreboard predicts every result in order.
// Depends on nbc_pkg and the top level of the engine.
`timescale 1ns / 1ps

module testbench;
  import nbc_pkg::*;

  localparam int unsigned PAGE_BYTES  = 2048;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned BLOCK_SHIFT = 18;
  localparam int unsigned ADDR_BITS   = 29;
  localparam logic [63:0] FLASH_END   = 64'd1 << ADDR_BITS;
  localparam logic [63:0] PAGE_IN_BLOCK =
    ((64'd1 << BLOCK_SHIFT) - 64'd1) & ~((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam int unsigned MAX_RESULTS = 10;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned STALL_LIMIT = 4000;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [2:0] REG_DEST_BASE   = 3'd0;
  localparam logic [2:0] REG_IMAGE_BYTES = 3'd4;

  localparam logic [7:0] MARK_GOOD = 8'hff;

  typedef enum logic [2:0] {
    STAGE_IDLE,
    STAGE_RESET_WAIT,
    STAGE_SPARE_WAIT,
    STAGE_SPARE_DATA,
    STAGE_PAGE_WAIT,
    STAGE_PAGE_DATA
  } copy_stage_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  value;
    logic [11:0] count;
    logic [31:0] addr;
    logic        status;
    logic        last;
  } flash_result_t;

  class boot_copy_scoreboard;
    bit [31:0]     dest_base;
    bit [24:0]     image_bytes;
    copy_stage_e   stage;
    bit [63:0]     flash_page;
    bit [10:0]     marked_block;
    bit            marked_valid;
    bit [25:0]     bytes_to_go;
    bit [31:0]     wr_ptr;
    bit [11:0]     page_pos;
    bit [7:0]      marker;
    flash_result_t batch[$];
    flash_result_t pending[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   mem_writes;

    function void reset_state();
      dest_base    = '0;
      image_bytes  = '0;
      stage        = STAGE_IDLE;
      flash_page   = '0;
      marked_block = '0;
      marked_valid = 1'b0;
      bytes_to_go  = '0;
      wr_ptr       = '0;
      page_pos     = '0;
      marker       = '0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      case (addr)
        REG_DEST_BASE:   dest_base = data;
        REG_IMAGE_BYTES: image_bytes = data[24:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [2:0] act, logic [7:0] val, logic [11:0] cnt,
                       logic [31:0] addr, logic st);
      flash_result_t r;
      if (batch.size() >= MAX_RESULTS) return;
      r = {act, val, cnt, addr, st, 1'b0};
      batch.push_back(r);
    endfunction

    function void issue_read(logic [63:0] a);
      emit(ACT_SELECT, 8'h00, 12'd0, 32'd0, 1'b0);
      emit(ACT_COMMAND, CMD_READ_A, 12'd0, 32'd0, 1'b0);
      emit(ACT_ADDRESS, a[7:0], 12'd0, 32'd0, 1'b0);
      emit(ACT_ADDRESS, 8'(a[PAGE_SHIFT-1:8]), 12'd0, 32'd0, 1'b0);
      emit(ACT_ADDRESS, a[PAGE_SHIFT+7:PAGE_SHIFT], 12'd0, 32'd0, 1'b0);
      emit(ACT_ADDRESS, a[PAGE_SHIFT+15:PAGE_SHIFT+8], 12'd0, 32'd0, 1'b0);
      emit(ACT_ADDRESS, 8'(a[ADDR_BITS-1:PAGE_SHIFT+16]), 12'd0, 32'd0, 1'b0);
      emit(ACT_COMMAND, CMD_READ_B, 12'd0, 32'd0, 1'b0);
    endfunction

    function void finish_copy(logic st);
      emit(ACT_DONE, 8'h00, 12'd0, 32'd0, st);
      stage = STAGE_IDLE;
    endfunction

    function void skip_block();
      flash_page = (flash_page & ~PAGE_IN_BLOCK) + (64'd1 << BLOCK_SHIFT);
    endfunction

    // pick the next flash read, skipping blocks already known bad
    function void advance();
      bit [10:0] blk;
      forever begin
        if (bytes_to_go == 0) begin
          finish_copy(1'b0);
          return;
        end
        if (flash_page >= FLASH_END) begin
          finish_copy(1'b1);
          return;
        end
        blk = flash_page[BLOCK_SHIFT +: (ADDR_BITS - BLOCK_SHIFT)];
        if (!marked_valid || blk != marked_block) begin
          marked_block = blk;
          marked_valid = 1'b1;
          issue_read(flash_page + PAGE_BYTES);
          stage = STAGE_SPARE_WAIT;
          return;
        end
        if (marker == MARK_GOOD) begin
          issue_read(flash_page);
          page_pos = '0;
          stage = STAGE_PAGE_WAIT;
          return;
        end
        skip_block();
      end
    endfunction

    function void note_item(logic [1:0] mode, logic [7:0] b);
      flash_result_t r;
      batch.delete();
      case (mode)
        MODE_START: if (stage == STAGE_IDLE) begin
          flash_page   = '0;
          marked_valid = 1'b0;
          marked_block = '0;
          marker       = '0;
          page_pos     = '0;
          bytes_to_go  = 26'(image_bytes);
          wr_ptr       = dest_base;
          emit(ACT_SELECT, 8'h00, 12'd0, 32'd0, 1'b0);
          emit(ACT_COMMAND, CMD_RESET, 12'd0, 32'd0, 1'b0);
          stage = STAGE_RESET_WAIT;
        end
        MODE_READY: case (stage)
          STAGE_RESET_WAIT: begin
            emit(ACT_UNSELECT, 8'h00, 12'd0, 32'd0, 1'b0);
            advance();
          end
          STAGE_SPARE_WAIT: begin
            emit(ACT_READ, 8'h00, 12'd1, 32'd0, 1'b0);
            stage = STAGE_SPARE_DATA;
          end
          STAGE_PAGE_WAIT: begin
            emit(ACT_READ, 8'h00, 12'(PAGE_BYTES), 32'd0, 1'b0);
            page_pos = '0;
            stage = STAGE_PAGE_DATA;
          end
          default: ;
        endcase
        MODE_DATA: case (stage)
          STAGE_SPARE_DATA: begin
            marker = b;
            emit(ACT_UNSELECT, 8'h00, 12'd0, 32'd0, 1'b0);
            if (b != MARK_GOOD) skip_block();
            advance();
          end
          STAGE_PAGE_DATA: begin
            emit(ACT_MEMWR, b, 12'd0, wr_ptr, 1'b0);
            mem_writes++;
            wr_ptr++;
            page_pos++;
            if (page_pos >= PAGE_BYTES) begin
              page_pos = '0;
              emit(ACT_UNSELECT, 8'h00, 12'd0, 32'd0, 1'b0);
              // the last page is copied whole, so saturate at zero
              bytes_to_go = (bytes_to_go > PAGE_BYTES) ?
                            bytes_to_go - 26'(PAGE_BYTES) : '0;
              flash_page += 64'd1 << PAGE_SHIFT;
              advance();
            end
          end
          default: ;
        endcase
        default: ;
      endcase
      foreach (batch[i]) begin
        r = batch[i];
        r.last = (i == batch.size() - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_result(flash_result_t got);
      flash_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: action %0d value %02h count %0d",
                   $realtime, got.action, got.value, got.count);
        return;
      end
      want = pending.pop_front();
      if (got.action !== want.action || got.value !== want.value ||
          got.count !== want.count || got.addr !== want.addr ||
          got.status !== want.status || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch, expected act %0d val %02h cnt %0d addr %08h st %0d last %0d",
                   $realtime, want.action, want.value, want.count, want.addr,
                   want.status, want.last);
          $display("%0t:                  got      act %0d val %02h cnt %0d addr %08h st %0d last %0d",
                   $realtime, got.action, got.value, got.count, got.addr,
                   got.status, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  action_o;
  logic [7:0]  value_o;
  logic [11:0] byte_count_o;
  logic [31:0] mem_addr_o;
  logic        status_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  boot_copy_scoreboard sb;
  logic [7:0]  marker_plan[$];
  bit          sender_steady;
  bit          calm_results;
  int unsigned items_taken;
  int unsigned copy_runs;
  int unsigned bad_blocks;
  int unsigned quiet_cycles;

  nand_boot_copy_bad_block_skip dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .action_o    (action_o),
    .value_o     (value_o),
    .byte_count_o(byte_count_o),
    .mem_addr_o  (mem_addr_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : monitor
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) sb.write_reg(paddr, pwdata);
      if (in_valid_i && !in_stall_o) begin
        sb.note_item(mode_i, data_byte_i);
        items_taken++;
      end
      if (out_valid_o && !out_stall_i)
        sb.check_result({action_o, value_o, byte_count_o, mem_addr_o, status_o, last_o});
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, sb.pending.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result back-pressure: stretches of none, light, heavy and long stalls
  initial begin : result_stall
    int unsigned style;
    int unsigned span;
    int unsigned hold;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      style = $urandom_range(3, 0);
      span  = $urandom_range(300, 30);
      repeat (span) begin
        @(negedge clk_i);
        if (hold != 0) hold--;
        else if (!calm_results && style == 3 && $urandom_range(39, 0) == 0)
          hold = $urandom_range(60, 15);
        if (hold != 0) out_stall_i <= 1'b1;
        else if (style == 0) out_stall_i <= 1'b0;
        else if (calm_results || style == 1) out_stall_i <= ($urandom_range(7, 0) == 0);
        else out_stall_i <= ($urandom_range(1, 0) == 0);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_steady) return 0;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 99) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off the sender until every predicted result has arrived
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending.size() != 0);
  endtask

  task automatic wait_drained();
    hold_until_drained();
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // an item the engine must ignore in its current stage
  task automatic send_noise();
    case ($urandom_range(2, 0))
      0: send_item(MODE_NONE, 8'($urandom));
      1: send_item(MODE_START, 8'($urandom));
      default:
        if (sb.stage == STAGE_SPARE_DATA || sb.stage == STAGE_PAGE_DATA)
          send_item(MODE_READY, 8'($urandom));
        else
          send_item(MODE_DATA, 8'($urandom));
    endcase
  endtask

  // one boot copy: configure, start, then answer as the flash until done or
  // until the item budget is spent
  task automatic boot_run(input logic [31:0] base, input logic [31:0] size_word,
                          input int unsigned bad_pct, input int unsigned noise_pct,
                          input bit calm, input int unsigned budget);
    logic [7:0]  b;
    int unsigned first_item;
    wait_drained();
    apb_write(REG_DEST_BASE, base);
    apb_write(REG_IMAGE_BYTES, size_word);
    calm_results  = calm;
    sender_steady = calm || ($urandom_range(3, 0) == 0);
    first_item    = items_taken;
    send_item(MODE_START, 8'($urandom));
    copy_runs++;
    while (sb.stage != STAGE_IDLE && items_taken - first_item < budget) begin
      if ($urandom_range(99, 0) < noise_pct) send_noise();
      if ($urandom_range(199, 0) == 0) hold_until_drained();
      case (sb.stage)
        STAGE_SPARE_DATA: begin
          if (marker_plan.size() != 0) begin
            b = marker_plan.pop_front();
          end else if ($urandom_range(99, 0) < bad_pct) begin
            do b = 8'($urandom); while (b == MARK_GOOD);
          end else begin
            b = MARK_GOOD;
          end
          if (b != MARK_GOOD) bad_blocks++;
          send_item(MODE_DATA, b);
        end
        STAGE_PAGE_DATA: send_item(MODE_DATA, 8'($urandom));
        default:         send_item(MODE_READY, 8'($urandom));
      endcase
    end
    calm_results  = 1'b0;
    sender_steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] size_word;
    sb = new;
    sb.reset_state();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_START;
    data_byte_i   = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = REG_DEST_BASE;
    pwdata        = 32'h0;
    sender_steady = 1'b0;
    calm_results  = 1'b0;
    items_taken   = 0;
    copy_runs     = 0;
    bad_blocks    = 0;
    quiet_cycles  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle engine: ready, data and the unused mode are all dropped
    send_item(MODE_READY, 8'h00);
    send_item(MODE_DATA, 8'hff);
    send_item(MODE_NONE, 8'h55);

    // empty image, with a second start while busy and a stray data byte
    wait_drained();
    apb_write(REG_DEST_BASE, 32'h0000_0000);
    apb_write(REG_IMAGE_BYTES, 32'h0000_0000);
    send_item(MODE_START, 8'hff);
    send_item(MODE_START, 8'h00);
    send_item(MODE_DATA, 8'h5a);
    send_item(MODE_READY, 8'haa);
    copy_runs++;

    // empty images at random bases; bits above the register width are dropped
    repeat (8) begin
      if ($urandom_range(1, 0) == 0) size_word = 32'd0;
      else size_word = {7'($urandom), 25'd0};
      boot_run($urandom, size_word, 0, 20, 1'b0, 64);
    end

    // three bad blocks, then part of a page that wraps the write pointer
    marker_plan = '{8'h00, 8'h7f, 8'hfe, MARK_GOOD};
    boot_run(32'hffff_ff80, 32'd5000, 0, 3, 1'b0, 230);

    wait_drained();
    $display("covered %0d copy runs, %0d bad blocks skipped, %0d memory writes",
             copy_runs, bad_blocks, sb.mem_writes);
    $display("%0d input transactions taken, %0d results checked, %0d mismatches",
             items_taken, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
